// ----- src/lsws_pkg.sv -----
package lsws_pkg;

  localparam int DEFAULT_STACK_DEPTH = 16;

  localparam int WORD_W   = 32;
  localparam int DEPTH_W  = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // pending result of the command in flight
  typedef struct packed {
    status_t             status;
    logic [WORD_W-1:0]   data;
    logic [DEPTH_W-1:0]  found_depth;
  } result_t;

endpackage

// ----- src/lsws_if.sv -----
interface lsws_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          command;
  logic signed [lsws_pkg::WORD_W-1:0]  value;
  logic [lsws_pkg::DEPTH_W-1:0]        depth_index;

  modport source (output valid, output command, output value, output depth_index,
                  input ready);
  modport sink (input valid, input command, input value, input depth_index,
                output ready);
endinterface

interface lsws_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [lsws_pkg::STATUS_W-1:0]       status;
  logic signed [lsws_pkg::WORD_W-1:0]  data;
  logic [lsws_pkg::DEPTH_W-1:0]        found_depth;
  logic [lsws_pkg::COUNT_W-1:0]        count;
  logic                                is_empty_flag;

  modport source (output valid, output status, output data, output found_depth,
                  output count, output is_empty_flag, input ready);
  modport sink (input valid, input status, input data, input found_depth,
                input count, input is_empty_flag, output ready);
endinterface

// ----- src/lsws_store.sv -----
module lsws_store #(
  parameter int STACK_DEPTH = lsws_pkg::DEFAULT_STACK_DEPTH,
  parameter int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [lsws_pkg::WORD_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [lsws_pkg::WORD_W-1:0] rdata
);

  // slot 0 is the bottom of the stack
  logic [lsws_pkg::WORD_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/lifo_stack_with_search_top.sv -----
// bounded lifo stack of signed 32-bit words with read-at-depth and search
//
// req channel: valid/ready transfer of command, value and depth_index
//   push stores value on top, pop removes the top word, read returns the word
//   depth_index below the top, search returns the depth of the topmost match
// rsp channel: valid/ready transfer of status, data, found_depth, count and
//   is_empty_flag; exactly one rsp transfer per req transfer, in order
//
// one command at a time; req.ready is high only while the sequencer is idle
//   push and any rejected command: result register, then the rsp register
//   pop and read: registered read port of the store, result register, rsp register
//   search: the single compare unit checks one stored word per cycle, top
//   first, and stops at the first match
//
// the rsp register parts the two sides: a new req is taken while a result
// still waits; a finished result then waits in the sequencer until the rsp
// register is free, so a stalled receiver holds off the following command
//
// reset (rst, synchronous) empties the stack and drops any pending result;
// the word store itself is not cleared, only slots below count are read
module lifo_stack_with_search_top #(
  parameter int STACK_DEPTH = lsws_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  lsws_req_if.sink         req,
  lsws_rsp_if.source       rsp
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  // common width for comparing depth_index against the count
  localparam int XW = (CW > lsws_pkg::DEPTH_W) ? CW : lsws_pkg::DEPTH_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t                       state, state_next;
  logic [CW-1:0]                count, count_next;
  logic [lsws_pkg::WORD_W-1:0]  key, key_next;
  logic [CW-1:0]                issue_idx, issue_idx_next;
  logic [CW-1:0]                cmp_idx, cmp_idx_next;
  logic                         cmp_valid, cmp_valid_next;
  lsws_pkg::result_t            res, res_next;

  // store port
  logic                         we;
  logic [AW-1:0]                waddr;
  logic                         re;
  logic [AW-1:0]                raddr;
  logic [lsws_pkg::WORD_W-1:0]  rdata;

  logic                         rsp_free;
  logic                         load_rsp;
  logic [CW-1:0]                top_slot;

  assign req.ready = (state == S_IDLE);
  assign rsp_free  = !rsp.valid || rsp.ready;
  assign load_rsp  = (state == S_DONE) && rsp_free;
  assign top_slot  = count - CW'(1);
  assign waddr     = count[AW-1:0];

  lsws_store #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (req.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    key_next       = key;
    issue_idx_next = issue_idx;
    cmp_idx_next   = cmp_idx;
    cmp_valid_next = 1'b0;
    res_next       = res;
    we             = 1'b0;
    re             = 1'b0;
    raddr          = top_slot[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_next.status      = lsws_pkg::ST_OK;
          res_next.data        = '0;
          res_next.found_depth = '0;
          state_next           = S_DONE;
          unique case (lsws_pkg::cmd_t'(req.command))
            lsws_pkg::CMD_PUSH: begin
              if (count == CW'(STACK_DEPTH)) begin
                res_next.status = lsws_pkg::ST_FULL;
              end else begin
                we         = 1'b1;
                count_next = count + CW'(1);
              end
            end
            lsws_pkg::CMD_POP: begin
              if (count == '0) begin
                res_next.status = lsws_pkg::ST_EMPTY;
              end else begin
                re         = 1'b1;
                count_next = top_slot;
                state_next = S_READ;
              end
            end
            lsws_pkg::CMD_READ: begin
              if (XW'(req.depth_index) >= XW'(count)) begin
                res_next.status = lsws_pkg::ST_RANGE;
              end else begin
                // depth is below count here, so it fits the count width
                re         = 1'b1;
                raddr      = AW'(top_slot - CW'(req.depth_index));
                state_next = S_READ;
              end
            end
            default: begin
              key_next = req.value;
              if (count == '0) begin
                res_next.status = lsws_pkg::ST_NOTFOUND;
              end else begin
                issue_idx_next = '0;
                state_next     = S_SEARCH;
              end
            end
          endcase
        end
      end

      S_READ: begin
        res_next.data = rdata;
        state_next    = S_DONE;
      end

      S_SEARCH: begin
        // fetch one word per cycle, compare it the cycle after
        if (issue_idx != count) begin
          re             = 1'b1;
          raddr          = AW'(top_slot - issue_idx);
          issue_idx_next = issue_idx + CW'(1);
          cmp_valid_next = 1'b1;
          cmp_idx_next   = issue_idx;
        end
        if (cmp_valid && (rdata == key)) begin
          res_next.status      = lsws_pkg::ST_OK;
          res_next.found_depth = lsws_pkg::DEPTH_W'(cmp_idx);
          state_next           = S_DONE;
        end else if (cmp_valid && (issue_idx == count)) begin
          // last stored word checked without a match
          res_next.status = lsws_pkg::ST_NOTFOUND;
          state_next      = S_DONE;
        end
      end

      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cmp_valid <= cmp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key       <= key_next;
    issue_idx <= issue_idx_next;
    cmp_idx   <= cmp_idx_next;
    res       <= res_next;
  end

  // result register toward the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.status        <= res.status;
      rsp.data          <= res.data;
      rsp.found_depth   <= res.found_depth;
      rsp.count         <= lsws_pkg::COUNT_W'(count);
      rsp.is_empty_flag <= (count == '0);
    end
  end

endmodule

// ----- tb/lifo_stack_with_search_top_tb.sv -----
`timescale 1ns / 100ps

module lifo_stack_with_search_top_tb;

  localparam int STACK_DEPTH = lsws_pkg::DEFAULT_STACK_DEPTH;
  localparam int SW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int TOTAL_CMDS  = 1840;   // directed part plus random part
  localparam int IDLE_LIMIT  = 3000;   // cycles with no transfer on either side
  localparam int TAIL_CYCLES = 40;     // longer than the slowest search

  // one command as the sender issues it
  typedef struct {
    lsws_pkg::cmd_t                       command;
    logic signed [lsws_pkg::WORD_W-1:0]   value;
    logic [lsws_pkg::DEPTH_W-1:0]         depth_index;
    bit                                   drain_first;   // hold off until all results are in
  } stack_cmd_t;

  // one result as the receiver should see it
  typedef struct {
    lsws_pkg::status_t                    status;
    logic signed [lsws_pkg::WORD_W-1:0]   data;
    logic [lsws_pkg::DEPTH_W-1:0]         found_depth;
    logic [lsws_pkg::COUNT_W-1:0]         count;
    logic                                 is_empty_flag;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst;

  lsws_req_if req_if ();
  lsws_rsp_if rsp_if ();

  lifo_stack_with_search_top #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transfer strobes, seen with their values from before the edge
  logic req_xfer, rsp_xfer;
  assign req_xfer = req_if.valid && req_if.ready;
  assign rsp_xfer = rsp_if.valid && rsp_if.ready;

  stack_cmd_t    pending_cmds[$];
  stack_result_t expected_results[$];
  stack_cmd_t    cur_cmd;
  int            accepted_cmds = 0;
  int            total_cmds = 0;
  int            mismatches = 0;
  int            idle_cycles = 0;

  // shadow copy of the stack, advanced once per accepted command
  logic [lsws_pkg::WORD_W-1:0] shadow_words [STACK_DEPTH];
  int                          shadow_fill = 0;

  // recently pushed words, so searches and duplicates actually hit
  logic signed [lsws_pkg::WORD_W-1:0] word_pool [8];

  // gap picker shared by both sides: mostly short, a few long, and
  // now and then a calm stretch with no gaps at all
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // word for a push or a search: extremes, pool hits or anything
  function automatic logic signed [lsws_pkg::WORD_W-1:0] choose_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      1, 2, 3: return word_pool[3'($urandom_range(0, 7))];
      default: return $urandom;
    endcase
  endfunction

  task automatic add_cmd(input lsws_pkg::cmd_t c,
                         input logic signed [lsws_pkg::WORD_W-1:0] v,
                         input logic [lsws_pkg::DEPTH_W-1:0] d, input bit hold);
    stack_cmd_t it;
    it.command     = c;
    it.value       = v;
    it.depth_index = d;
    it.drain_first = hold;
    pending_cmds.push_back(it);
    if (c == lsws_pkg::CMD_PUSH) word_pool[3'($urandom_range(0, 7))] = v;
  endtask

  // expected result of one command; updates the shadow stack
  function automatic stack_result_t predict_result(input stack_cmd_t it);
    stack_result_t r;
    int i;
    bit hit;
    r.status      = lsws_pkg::ST_OK;
    r.data        = '0;
    r.found_depth = '0;
    case (it.command)
      lsws_pkg::CMD_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          r.status = lsws_pkg::ST_FULL;
        end else begin
          shadow_words[SW'(shadow_fill)] = it.value;
          shadow_fill++;
        end
      end
      lsws_pkg::CMD_POP: begin
        if (shadow_fill == 0) begin
          r.status = lsws_pkg::ST_EMPTY;
        end else begin
          shadow_fill--;
          r.data = shadow_words[SW'(shadow_fill)];
        end
      end
      lsws_pkg::CMD_READ: begin
        // covers every read of an empty stack
        if (int'(it.depth_index) >= shadow_fill) begin
          r.status = lsws_pkg::ST_RANGE;
        end else begin
          r.data = shadow_words[SW'(shadow_fill - 1 - int'(it.depth_index))];
        end
      end
      default: begin
        // topmost match wins; no match, or an empty stack, is not-found
        r.status = lsws_pkg::ST_NOTFOUND;
        hit = 1'b0;
        for (i = 0; i < shadow_fill && !hit; i++) begin
          if (shadow_words[SW'(shadow_fill - 1 - i)] == it.value) begin
            hit = 1'b1;
            r.status = lsws_pkg::ST_OK;
            r.found_depth = i[lsws_pkg::DEPTH_W-1:0];
          end
        end
      end
    endcase
    r.count         = shadow_fill[lsws_pkg::COUNT_W-1:0];
    r.is_empty_flag = (shadow_fill == 0);
    return r;
  endfunction

  // command driver: one command held on the req channel until its transfer
  int gap_left = 0;
  int req_calm = 0;

  always @(posedge clk) begin : cmd_driver
    bit took;
    took = req_xfer;
    if (rst) begin
      req_if.valid       <= 1'b0;
      req_if.command     <= lsws_pkg::CMD_PUSH;
      req_if.value       <= '0;
      req_if.depth_index <= '0;
      gap_left = 0;
    end else begin
      if (took) begin
        expected_results.push_back(predict_result(cur_cmd));
        accepted_cmds++;
        gap_left = pick_gap(req_calm);
      end
      if (req_if.valid && !took) begin
        // keep the current command on the bus
      end else if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pending_cmds.size() != 0 &&
                   (!pending_cmds[0].drain_first ||
                    (expected_results.size() == 0 && !rsp_xfer && !took))) begin
        cur_cmd = pending_cmds.pop_front();
        req_if.valid       <= 1'b1;
        req_if.command     <= cur_cmd.command;
        req_if.value       <= cur_cmd.value;
        req_if.depth_index <= cur_cmd.depth_index;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result monitor: every rsp transfer is checked against the oldest expectation
  int stall_left = 0;
  int rsp_calm = 0;

  always @(posedge clk) begin : rsp_monitor
    stack_result_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_xfer) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with no command outstanding", $realtime);
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.status !== want.status || rsp_if.data !== want.data ||
              rsp_if.found_depth !== want.found_depth ||
              rsp_if.count !== want.count ||
              rsp_if.is_empty_flag !== want.is_empty_flag) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: exp/act st %0d/%0d data %h/%h fd %0d/%0d cnt %0d/%0d emp %0b/%0b",
                       $realtime, want.status, rsp_if.status, want.data, rsp_if.data,
                       want.found_depth, rsp_if.found_depth, want.count, rsp_if.count,
                       want.is_empty_flag, rsp_if.is_empty_flag);
          end
        end
      end
      // stalls start after a transfer or at any other moment
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (rsp_xfer || $urandom_range(0, 15) == 0) begin
        stall_left = pick_gap(rsp_calm);
        if (stall_left > 0) begin
          stall_left--;
          rsp_if.ready <= 1'b0;
        end else begin
          rsp_if.ready <= 1'b1;
        end
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || req_xfer || rsp_xfer) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int kind, n, k;
    bit hold;
    lsws_pkg::cmd_t c;

    rst = 1'b1;
    for (k = 0; k < 8; k++) word_pool[k] = $urandom;

    // directed: empty-stack cases first
    add_cmd(lsws_pkg::CMD_POP,    32'sd0, 4'd0, 1'b0);
    add_cmd(lsws_pkg::CMD_READ,   32'sd0, 4'd0, 1'b0);
    add_cmd(lsws_pkg::CMD_READ,   -32'sd1, 4'd15, 1'b0);
    add_cmd(lsws_pkg::CMD_SEARCH, 32'sd0, 4'd0, 1'b0);
    // extremes of the word
    add_cmd(lsws_pkg::CMD_PUSH,   32'sh7FFF_FFFF, 4'd15, 1'b0);
    add_cmd(lsws_pkg::CMD_PUSH,   32'sh8000_0000, 4'd0, 1'b0);
    add_cmd(lsws_pkg::CMD_PUSH,   -32'sd1, 4'd0, 1'b0);
    add_cmd(lsws_pkg::CMD_PUSH,   32'sd0, 4'd0, 1'b0);
    // reads at the top, at the bottom and one past the count
    add_cmd(lsws_pkg::CMD_READ,   32'sh7FFF_FFFF, 4'd0, 1'b0);
    add_cmd(lsws_pkg::CMD_READ,   32'sd0, 4'd3, 1'b0);
    add_cmd(lsws_pkg::CMD_READ,   32'sd0, 4'd4, 1'b0);
    // search hits below the top and a miss
    add_cmd(lsws_pkg::CMD_SEARCH, -32'sd1, 4'd0, 1'b0);
    add_cmd(lsws_pkg::CMD_SEARCH, 32'sh8000_0000, 4'd0, 1'b0);
    add_cmd(lsws_pkg::CMD_SEARCH, 32'sh1234_5678, 4'd0, 1'b0);
    // duplicates: the topmost copy must be reported
    add_cmd(lsws_pkg::CMD_PUSH,   32'sd5, 4'd0, 1'b0);
    add_cmd(lsws_pkg::CMD_PUSH,   32'sd5, 4'd0, 1'b0);
    add_cmd(lsws_pkg::CMD_SEARCH, 32'sd5, 4'd0, 1'b0);
    add_cmd(lsws_pkg::CMD_POP,    32'sd0, 4'd0, 1'b0);
    add_cmd(lsws_pkg::CMD_POP,    -32'sd1, 4'd15, 1'b0);
    add_cmd(lsws_pkg::CMD_READ,   32'sd0, 4'd15, 1'b0);

    // random episodes: fill to full, drain past empty, mixed traffic, noise
    hold = 1'b1;
    while (pending_cmds.size() < TOTAL_CMDS) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        n = $urandom_range(12, 20);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 9) == 0)
            add_cmd(lsws_pkg::CMD_SEARCH, choose_word(),
                    lsws_pkg::DEPTH_W'($urandom), hold);
          else if ($urandom_range(0, 9) == 0)
            add_cmd(lsws_pkg::CMD_READ, $urandom, lsws_pkg::DEPTH_W'($urandom), hold);
          else
            add_cmd(lsws_pkg::CMD_PUSH, choose_word(),
                    lsws_pkg::DEPTH_W'($urandom), hold);
          hold = 1'b0;
        end
      end else if (kind < 55) begin
        n = $urandom_range(12, 20);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 7) == 0)
            add_cmd(lsws_pkg::CMD_READ, $urandom, lsws_pkg::DEPTH_W'($urandom), hold);
          else
            add_cmd(lsws_pkg::CMD_POP, $urandom, lsws_pkg::DEPTH_W'($urandom), hold);
          hold = 1'b0;
        end
      end else if (kind < 90) begin
        n = $urandom_range(8, 30);
        for (k = 0; k < n; k++) begin
          c = lsws_pkg::cmd_t'($urandom_range(0, 3));
          if (c == lsws_pkg::CMD_PUSH || c == lsws_pkg::CMD_SEARCH)
            add_cmd(c, choose_word(), lsws_pkg::DEPTH_W'($urandom), hold);
          else
            add_cmd(c, $urandom, lsws_pkg::DEPTH_W'($urandom), hold);
          hold = 1'b0;
        end
      end else begin
        n = $urandom_range(3, 10);
        for (k = 0; k < n; k++) begin
          add_cmd(lsws_pkg::cmd_t'($urandom_range(0, 3)), $urandom,
                  lsws_pkg::DEPTH_W'($urandom), hold);
          hold = 1'b0;
        end
      end
      // now and then let everything drain before the next episode
      if ($urandom_range(0, 39) == 0) hold = 1'b1;
    end
    total_cmds = pending_cmds.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cmds < total_cmds) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/lsws_pkg.sv
src/lsws_if.sv
src/lsws_store.sv
src/lifo_stack_with_search_top.sv
tb/lifo_stack_with_search_top_tb.sv
